[sv/ppu_pkg.sv]
// Shared types, codes and arithmetic helpers for the particle pool update block.
`timescale 1ns / 1ps
package ppu_pkg;

	localparam int POOL_SLOTS_DEF = 1024;
	localparam logic [31:0] LIFE_RESET = 32'h0001_0000;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] REG_ACCEL_X   = 2'd0;
	localparam logic [1:0] REG_ACCEL_Y   = 2'd1;
	localparam logic [1:0] REG_ACCEL_Z   = 2'd2;
	localparam logic [1:0] REG_LIFE_SPAN = 2'd3;

	typedef logic [2:0][31:0] vec3_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_INS1,
		OP_INS2,
		OP_INS3,
		OP_RM_RD,
		OP_RM_CHK,
		OP_UNL1,
		OP_UNL2,
		OP_UNL3,
		OP_TK_RD,
		OP_TK_MUL1,
		OP_TK_VADD,
		OP_TK_MUL2,
		OP_TK_PADD,
		OP_TK_NEXT,
		OP_RES_OK,
		OP_RES_FAIL
	} op_t;

	typedef struct packed {
		logic free_nil;
		logic cur_nil;
		logic rm_ok;
		logic expired;
		logic clr_last;
		logic out_free;
	} ppu_stat_t;

	// Signed 32-bit plus signed 33-bit, clamped to the signed 32-bit range.
	function automatic logic [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [32:0] b);
		logic signed [33:0] s;
		s = 34'(a) + 34'(b);
		if (!s[33] && (s[32:31] != 2'b00)) begin
			return 32'h7FFF_FFFF;
		end else if (s[33] && (s[32:31] != 2'b11)) begin
			return 32'h8000_0000;
		end else begin
			return s[31:0];
		end
	endfunction

endpackage

[sv/ppu_ctrl.sv]
// Sequencer for the particle pool: one-hot state machine issuing datapath operations.
`timescale 1ns / 1ps
module ppu_ctrl import ppu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic [1:0] cmd,
	output logic      in_stall,
	input  ppu_stat_t stat,
	output op_t       op
);

	typedef enum logic [18:0] {
		S_CLEAR     = 19'h00001,
		S_IDLE      = 19'h00002,
		S_INS1      = 19'h00004,
		S_INS2      = 19'h00008,
		S_INS3      = 19'h00010,
		S_RM_RD     = 19'h00020,
		S_RM_CHK    = 19'h00040,
		S_UNL1      = 19'h00080,
		S_UNL2      = 19'h00100,
		S_UNL3      = 19'h00200,
		S_TK_RD     = 19'h00400,
		S_TK_MUL1   = 19'h00800,
		S_TK_VADD   = 19'h01000,
		S_TK_MUL2   = 19'h02000,
		S_TK_PADD   = 19'h04000,
		S_TK_DEC    = 19'h08000,
		S_TK_NEXT   = 19'h10000,
		S_DONE_OK   = 19'h20000,
		S_DONE_FAIL = 19'h40000
	} state_t;

	state_t state_q, state_d;
	logic   tick_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		case (state_q)
			S_CLEAR: begin
				op = OP_CLR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					op = OP_LOAD;
					case (cmd)
						CMD_INSERT: state_d = stat.free_nil ? S_DONE_FAIL : S_INS1;
						CMD_REMOVE: state_d = S_RM_RD;
						CMD_TICK:   state_d = S_TK_RD;
						default:    state_d = S_DONE_FAIL;
					endcase
				end
			end
			S_INS1: begin
				op = OP_INS1;
				state_d = S_INS2;
			end
			S_INS2: begin
				op = OP_INS2;
				state_d = S_INS3;
			end
			S_INS3: begin
				op = OP_INS3;
				state_d = S_DONE_OK;
			end
			S_RM_RD: begin
				op = OP_RM_RD;
				state_d = S_RM_CHK;
			end
			S_RM_CHK: begin
				op = OP_RM_CHK;
				state_d = stat.rm_ok ? S_UNL1 : S_DONE_FAIL;
			end
			S_UNL1: begin
				op = OP_UNL1;
				state_d = S_UNL2;
			end
			S_UNL2: begin
				op = OP_UNL2;
				state_d = S_UNL3;
			end
			S_UNL3: begin
				op = OP_UNL3;
				state_d = tick_q ? S_TK_NEXT : S_DONE_OK;
			end
			S_TK_RD: begin
				if (stat.cur_nil) begin
					state_d = S_DONE_OK;
				end else begin
					op = OP_TK_RD;
					state_d = S_TK_MUL1;
				end
			end
			S_TK_MUL1: begin
				op = OP_TK_MUL1;
				state_d = S_TK_VADD;
			end
			S_TK_VADD: begin
				op = OP_TK_VADD;
				state_d = S_TK_MUL2;
			end
			S_TK_MUL2: begin
				op = OP_TK_MUL2;
				state_d = S_TK_PADD;
			end
			S_TK_PADD: begin
				op = OP_TK_PADD;
				state_d = S_TK_DEC;
			end
			S_TK_DEC: begin
				state_d = stat.expired ? S_UNL1 : S_TK_NEXT;
			end
			S_TK_NEXT: begin
				op = OP_TK_NEXT;
				state_d = S_TK_RD;
			end
			S_DONE_OK: begin
				if (stat.out_free) begin
					op = OP_RES_OK;
					state_d = S_IDLE;
				end
			end
			S_DONE_FAIL: begin
				if (stat.out_free) begin
					op = OP_RES_FAIL;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			tick_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_LOAD) tick_q <= (cmd == CMD_TICK);
		end
	end

endmodule

[sv/ppu_dpath.sv]
// Particle pool datapath: slot memories, list pointers, Euler arithmetic and result register.
`timescale 1ns / 1ps
module ppu_dpath import ppu_pkg::*; #(
	parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         op,
	output ppu_stat_t   stat,
	input  logic [1:0]  cmd,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	input  logic [9:0]  slot_in,
	input  logic [15:0] step_secs,
	input  logic [31:0] accel_x,
	input  logic [31:0] accel_y,
	input  logic [31:0] accel_z,
	input  logic [31:0] life_span,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [9:0]  slot_out,
	output logic [10:0] live_count,
	output logic [10:0] expired_count
);

	localparam int SW = $clog2(POOL_SLOTS);
	localparam int LW = SW + 1;
	localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);

	// Slot memories
	vec3_t          pos_mem  [POOL_SLOTS];
	vec3_t          vel_mem  [POOL_SLOTS];
	logic [31:0]    age_mem  [POOL_SLOTS];
	logic [LW-1:0]  next_mem [POOL_SLOTS];
	logic [LW-1:0]  prev_mem [POOL_SLOTS];
	logic           live_mem [POOL_SLOTS];

	logic [LW-1:0] free_head_q, used_head_q, total_q, expired_q;
	logic [LW-1:0] cur_q, nx_q, pv_q;
	logic [SW-1:0] clr_q, slot_q;
	logic          range_q;
	logic [1:0]    cmd_q;
	logic [15:0]   dt_q;
	vec3_t         pos_in_q, vel_in_q;
	vec3_t         rd_pos_q, rd_vel_q, vnew_q;
	logic [31:0]   rd_age_q, age_q;
	logic [LW-1:0] rd_next_q, rd_prev_q;
	logic          rd_live_q;
	logic          exp_q;
	logic signed [48:0] prod_a_q [3];
	logic signed [48:0] prod_v_q [3];

	logic          out_valid_q, ok_q;
	logic [9:0]    slot_out_q;
	logic [10:0]   live_q, exp_cnt_q;

	// Port-side memory controls
	logic          rd_en;
	logic [SW-1:0] rd_a;
	logic          next_we, prev_we, live_we, dat_we;
	logic [SW-1:0] next_wa, prev_wa, live_wa, dat_wa;
	logic [LW-1:0] next_wd, prev_wd;
	logic          live_wd;
	vec3_t         pos_wd, vel_wd;
	logic [31:0]   age_wd;

	vec3_t         accel, pnew, vsum;
	logic [32:0]   age_sum;
	logic signed [16:0] dt_s;

	assign accel   = {accel_z, accel_y, accel_x};
	assign dt_s    = $signed({1'b0, dt_q});
	assign age_sum = {1'b0, rd_age_q} + {17'b0, dt_q};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vsum[k] = sat_add($signed(rd_vel_q[k]), prod_a_q[k][48:16]);
			pnew[k] = sat_add($signed(rd_pos_q[k]), prod_v_q[k][48:16]);
		end
	end

	assign stat.free_nil = (free_head_q == NIL);
	assign stat.cur_nil  = (cur_q == NIL);
	assign stat.rm_ok    = range_q && rd_live_q;
	assign stat.expired  = exp_q;
	assign stat.clr_last = (clr_q == SW'(POOL_SLOTS - 1));
	assign stat.out_free = !out_valid_q || !out_stall;

	always_comb begin
		rd_en   = 1'b0;
		rd_a    = cur_q[SW-1:0];
		next_we = 1'b0;
		next_wa = cur_q[SW-1:0];
		next_wd = NIL;
		prev_we = 1'b0;
		prev_wa = cur_q[SW-1:0];
		prev_wd = NIL;
		live_we = 1'b0;
		live_wa = cur_q[SW-1:0];
		live_wd = 1'b0;
		dat_we  = 1'b0;
		dat_wa  = cur_q[SW-1:0];
		pos_wd  = pnew;
		vel_wd  = vnew_q;
		age_wd  = age_q;
		case (op)
			OP_CLR: begin
				next_we = 1'b1;
				next_wa = clr_q;
				next_wd = {1'b0, clr_q} + LW'(1);
				prev_we = 1'b1;
				prev_wa = clr_q;
				prev_wd = (clr_q == '0) ? NIL : ({1'b0, clr_q} - LW'(1));
				live_we = 1'b1;
				live_wa = clr_q;
			end
			OP_INS1: begin
				rd_en   = 1'b1;
				rd_a    = free_head_q[SW-1:0];
				next_we = 1'b1;
				next_wa = free_head_q[SW-1:0];
				next_wd = used_head_q;
				prev_we = 1'b1;
				prev_wa = free_head_q[SW-1:0];
				live_we = 1'b1;
				live_wa = free_head_q[SW-1:0];
				live_wd = 1'b1;
				dat_we  = 1'b1;
				dat_wa  = free_head_q[SW-1:0];
				pos_wd  = pos_in_q;
				vel_wd  = vel_in_q;
				age_wd  = '0;
			end
			OP_INS2: begin
				prev_we = (used_head_q != NIL);
				prev_wa = used_head_q[SW-1:0];
				prev_wd = cur_q;
			end
			OP_INS3: begin
				prev_we = (free_head_q != NIL);
				prev_wa = free_head_q[SW-1:0];
			end
			OP_RM_RD: begin
				rd_en = 1'b1;
				rd_a  = slot_q;
			end
			OP_UNL1: begin
				next_we = (pv_q != NIL);
				next_wa = pv_q[SW-1:0];
				next_wd = nx_q;
				prev_we = (nx_q != NIL);
				prev_wa = nx_q[SW-1:0];
				prev_wd = pv_q;
				live_we = 1'b1;
			end
			OP_UNL2: begin
				prev_we = (free_head_q != NIL);
				prev_wa = free_head_q[SW-1:0];
				prev_wd = cur_q;
				next_we = 1'b1;
				next_wd = free_head_q;
			end
			OP_UNL3: begin
				prev_we = 1'b1;
			end
			OP_TK_RD: begin
				rd_en = 1'b1;
			end
			OP_TK_PADD: begin
				dat_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (live_we) live_mem[live_wa] <= live_wd;
		if (dat_we) begin
			pos_mem[dat_wa] <= pos_wd;
			vel_mem[dat_wa] <= vel_wd;
			age_mem[dat_wa] <= age_wd;
		end
		if (rd_en) begin
			rd_next_q <= next_mem[rd_a];
			rd_prev_q <= prev_mem[rd_a];
			rd_live_q <= live_mem[rd_a];
			rd_pos_q  <= pos_mem[rd_a];
			rd_vel_q  <= vel_mem[rd_a];
			rd_age_q  <= age_mem[rd_a];
		end
	end

	// Payload and working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				cmd_q    <= cmd;
				cur_q    <= used_head_q;
				slot_q   <= SW'(slot_in);
				range_q  <= (32'(slot_in) < 32'(POOL_SLOTS));
				dt_q     <= step_secs;
				pos_in_q <= {pos_z, pos_y, pos_x};
				vel_in_q <= {vel_z, vel_y, vel_x};
			end
			OP_INS1: cur_q <= free_head_q;
			OP_RM_CHK: begin
				cur_q <= LW'(slot_q);
				nx_q  <= rd_next_q;
				pv_q  <= rd_prev_q;
			end
			OP_TK_MUL1: begin
				nx_q  <= rd_next_q;
				pv_q  <= rd_prev_q;
				age_q <= age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
				for (int k = 0; k < 3; k++) begin
					prod_a_q[k] <= $signed(accel[k]) * dt_s;
				end
			end
			OP_TK_VADD: vnew_q <= vsum;
			OP_TK_MUL2: begin
				for (int k = 0; k < 3; k++) begin
					prod_v_q[k] <= $signed(vnew_q[k]) * dt_s;
				end
			end
			OP_TK_PADD: exp_q <= (age_q > life_span);
			OP_TK_NEXT: cur_q <= nx_q;
			OP_RES_OK, OP_RES_FAIL: begin
				ok_q       <= (op == OP_RES_OK);
				slot_out_q <= ((op == OP_RES_OK) && (cmd_q == CMD_INSERT)) ? 10'(cur_q) : '0;
				live_q     <= 11'(total_q);
				exp_cnt_q  <= 11'(expired_q);
			end
			default: begin
			end
		endcase
	end

	// List heads, counts and handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			used_head_q <= NIL;
			total_q     <= '0;
			expired_q   <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (op)
				OP_CLR:  clr_q <= clr_q + SW'(1);
				OP_LOAD: expired_q <= '0;
				OP_INS2: begin
					free_head_q <= rd_next_q;
					used_head_q <= cur_q;
					total_q     <= total_q + LW'(1);
				end
				OP_UNL1: if (pv_q == NIL) used_head_q <= nx_q;
				OP_UNL3: begin
					free_head_q <= cur_q;
					total_q     <= total_q - LW'(1);
				end
				OP_TK_NEXT: if (exp_q) expired_q <= expired_q + LW'(1);
				default: begin
				end
			endcase
			if (op == OP_RES_OK || op == OP_RES_FAIL) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign slot_out      = slot_out_q;
	assign live_count    = live_q;
	assign expired_count = exp_cnt_q;

endmodule

[sv/particle_pool_update.sv]
// Top level of the particle pool update block: configuration registers, sequencer and datapath.
`timescale 1ns / 1ps
// The block keeps a fixed pool of particle slots on a free list and a live list.
// Each input item carries a command (insert, remove or tick) with its payload, and
// each accepted item yields exactly one result item: a success flag, the granted
// slot, the live count after the item and the number of particles a tick expired.
// Both channels use valid and stall; an item moves when valid is high and stall low.
// Acceleration and lifetime are set through the APB-style port; the user must
// write them only while idle, as the block itself does not enforce it.
// An insert links the head of the free list into the live list and fails when
// the pool is full; a remove checks that the slot is live and unlinks it; a tick
// walks the live list, updates each particle and unlinks each one that expires.
// Each particle's two dependent Euler steps, velocity and then position, run
// one after the other, each for all three axes at once.
// After reset a pass over all POOL_SLOTS slots initialises the link memories,
// one slot per cycle; in_stall stays high during it while configuration writes
// are still taken. The result sits in an output register, so the next item is
// accepted while a result waits; if the receiver stalls that result, the block
// holds the following result internally until the register frees up.
module particle_pool_update import ppu_pkg::*; #(
	parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	input  logic [9:0]  slot_in,
	input  logic [15:0] step_secs,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [9:0]  slot_out,
	output logic [10:0] live_count,
	output logic [10:0] expired_count,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] accel_x_q, accel_y_q, accel_z_q, life_span_q;
	logic        cfg_wr;
	op_t         op;
	ppu_stat_t   stat;

	// Registers sit on word addresses; the low two address bits are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_x_q   <= '0;
			accel_y_q   <= '0;
			accel_z_q   <= '0;
			life_span_q <= LIFE_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ACCEL_X:   accel_x_q   <= pwdata;
				REG_ACCEL_Y:   accel_y_q   <= pwdata;
				REG_ACCEL_Z:   accel_z_q   <= pwdata;
				REG_LIFE_SPAN: life_span_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ACCEL_X:   prdata = accel_x_q;
			REG_ACCEL_Y:   prdata = accel_y_q;
			REG_ACCEL_Z:   prdata = accel_z_q;
			REG_LIFE_SPAN: prdata = life_span_q;
			default:       prdata = '0;
		endcase
	end

	// The sequencer owns the input handshake and steps the datapath one
	// operation per cycle at most; the datapath reports list and result status back.
	ppu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.stat     (stat),
		.op       (op)
	);

	ppu_dpath #(
		.POOL_SLOTS (POOL_SLOTS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.stat          (stat),
		.cmd           (cmd),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.vel_z         (vel_z),
		.slot_in       (slot_in),
		.step_secs     (step_secs),
		.accel_x       (accel_x_q),
		.accel_y       (accel_y_q),
		.accel_z       (accel_z_q),
		.life_span     (life_span_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ok            (ok),
		.slot_out      (slot_out),
		.live_count    (live_count),
		.expired_count (expired_count)
	);

endmodule

[sv/ppu_checker.sv]
// Port-level checks for the particle pool update block, bound to the top level.
`timescale 1ns / 1ps
module ppu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        ok,
	input logic [9:0]  slot_out,
	input logic [10:0] live_count,
	input logic [10:0] expired_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(live_count) && $stable(slot_out))
		else $error("stalled result item changed");

	a_slot_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (slot_out != 10'd0) |-> ok)
		else $error("slot reported on a failed item");

	a_expired_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (expired_count != 11'd0) |-> ok && (slot_out == 10'd0))
		else $error("expired count on an item that is not a tick");

endmodule

bind particle_pool_update ppu_checker u_ppu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.ok            (ok),
	.slot_out      (slot_out),
	.live_count    (live_count),
	.expired_count (expired_count)
);

[dv/tb_particle_pool_update.sv]
// Self-checking testbench for the particle pool update block.
`timescale 1ns / 1ps
module tb_particle_pool_update;
	import ppu_pkg::*;

	localparam int SLOTS = 1024;
	localparam int NIL = SLOTS;
	localparam int CYCLE_LIMIT = 20000000;

	// One result item as the block reports it.
	typedef struct {
		logic        ok;
		logic [9:0]  slot;
		logic [10:0] live;
		logic [10:0] expired;
	} pool_result_t;

	// The scoreboard keeps its own copy of the pool, works out the result of every
	// accepted item and checks the block's results against them in order.
	class pool_scoreboard;
		logic signed [31:0] pos [SLOTS][3];
		logic signed [31:0] vel [SLOTS][3];
		logic [31:0] age [SLOTS];
		int nxt [SLOTS];
		int prv [SLOTS];
		bit live [SLOTS];
		int free_head;
		int used_head;
		int used_total;
		logic signed [31:0] accel [3];
		logic [31:0] life_span;
		pool_result_t pending [$];
		int errors;

		function void clear();
			for (int i = 0; i < SLOTS; i++) begin
				nxt[i] = i + 1;
				prv[i] = (i == 0) ? NIL : i - 1;
				live[i] = 0;
			end
			free_head = 0;
			used_head = NIL;
			used_total = 0;
			for (int k = 0; k < 3; k++) accel[k] = 0;
			life_span = 32'h0001_0000;
			errors = 0;
		endfunction

		function void set_reg(int idx, logic [31:0] v);
			if (idx < 3) accel[idx] = v;
			else life_span = v;
		endfunction

		// Product with dt, floored division by 2^16.
		function logic signed [63:0] scaled(logic signed [31:0] x, logic [15:0] dt);
			logic signed [63:0] p;
			p = 64'(x) * $signed({48'd0, dt});
			return p >>> 16;
		endfunction

		function logic signed [31:0] clamp_add(logic signed [31:0] a,
			logic signed [63:0] b);
			logic signed [63:0] s;
			s = 64'(a) + b;
			if (s > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
			if (s < -64'sh8000_0000) return 32'sh8000_0000;
			return s[31:0];
		endfunction

		function void release_slot(int s);
			int p;
			int n;
			p = prv[s];
			n = nxt[s];
			if (p < NIL) nxt[p] = n;
			else used_head = n;
			if (n < NIL) prv[n] = p;
			if (free_head < NIL) prv[free_head] = s;
			nxt[s] = free_head;
			prv[s] = NIL;
			free_head = s;
			live[s] = 0;
			used_total--;
		endfunction

		function void note_item(logic [1:0] c, logic [31:0] p3 [3], logic [31:0] v3 [3],
			logic [9:0] sl, logic [15:0] dt);
			pool_result_t r;
			int s;
			int nx;
			logic [32:0] a;
			r.ok = 0;
			r.slot = 0;
			r.expired = 0;
			if (c == CMD_INSERT) begin
				if (free_head < NIL) begin
					s = free_head;
					for (int k = 0; k < 3; k++) begin
						pos[s][k] = p3[k];
						vel[s][k] = v3[k];
					end
					age[s] = 0;
					free_head = nxt[s];
					if (free_head < NIL) prv[free_head] = NIL;
					if (used_head < NIL) prv[used_head] = s;
					nxt[s] = used_head;
					prv[s] = NIL;
					used_head = s;
					live[s] = 1;
					used_total++;
					r.ok = 1;
					r.slot = 10'(s);
				end
			end else if (c == CMD_REMOVE) begin
				if (live[sl]) begin
					release_slot(sl);
					r.ok = 1;
				end
			end else if (c == CMD_TICK) begin
				s = used_head;
				while (s < NIL) begin
					nx = nxt[s];
					for (int k = 0; k < 3; k++) begin
						vel[s][k] = clamp_add(vel[s][k], scaled(accel[k], dt));
						pos[s][k] = clamp_add(pos[s][k], scaled(vel[s][k], dt));
					end
					a = {1'b0, age[s]} + dt;
					age[s] = a[32] ? 32'hFFFF_FFFF : a[31:0];
					if (age[s] > life_span) begin
						release_slot(s);
						r.expired++;
					end
					s = nx;
				end
				r.ok = 1;
			end
			r.live = 11'(used_total);
			pending.push_back(r);
		endfunction

		task report(string what, int got, int want);
			$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(pool_result_t got);
			pool_result_t want;
			if (pending.size() == 0) begin
				report("unexpected result item", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.ok !== want.ok) report("ok", got.ok, want.ok);
			if (got.slot !== want.slot) report("slot_out", got.slot, want.slot);
			if (got.live !== want.live) report("live_count", got.live, want.live);
			if (got.expired !== want.expired)
				report("expired_count", got.expired, want.expired);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] cmd = CMD_INSERT;
	logic [31:0] pos_x = 0, pos_y = 0, pos_z = 0, vel_x = 0, vel_y = 0, vel_z = 0;
	logic [9:0] slot_in = 0;
	logic [15:0] step_secs = 0;
	logic out_valid;
	logic out_stall = 0;
	logic ok;
	logic [9:0] slot_out;
	logic [10:0] live_count, expired_count;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;

	// Idle rates in percent; the stimulus process changes them between phases.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;
	pool_scoreboard board;

	particle_pool_update uut (.*);

	always #5 clk = ~clk;

	// The receiver decides its stall at each falling edge, so that it is settled
	// well before the rising edge at which the result is taken.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Results are sampled at the rising edge, where the handshake completes.
	always @(posedge clk) begin
		pool_result_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.ok = ok;
			r.slot = slot_out;
			r.live = live_count;
			r.expired = expired_count;
			board.check_result(r);
		end
	end

	// Watchdog: the slowest correct run is far inside this bound, the reset
	// clearing pass included.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Register write in a setup phase and then an access phase.
	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		board.set_reg(idx, v);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	// Presents one item and holds it until the block takes it. Called at a falling
	// edge; returns at a falling edge with valid still high, so the caller either
	// drives the next item or lowers valid without a second assignment in one step.
	task automatic send_item(logic [1:0] c, logic [31:0] p3 [3], logic [31:0] v3 [3],
		logic [9:0] sl, logic [15:0] dt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		pos_x <= p3[0];
		pos_y <= p3[1];
		pos_z <= p3[2];
		vel_x <= v3[0];
		vel_y <= v3[1];
		vel_z <= v3[2];
		slot_in <= sl;
		step_secs <= dt;
		do @(posedge clk); while (in_stall);
		board.note_item(c, p3, v3, sl, dt);
		@(negedge clk);
	endtask

	// Lowers valid and waits until every expected result has come before anything
	// else happens.
	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(4095) - 2048;
			3: return $urandom_range(2000000) - 1000000;
			default: return $urandom;
		endcase
	endfunction

	// Most removes name a slot that may well be live; some name any slot at all.
	function automatic logic [9:0] pick_slot();
		if ($urandom_range(3) == 0) return 10'($urandom);
		return 10'($urandom_range(63));
	endfunction

	task automatic random_items(int count);
		logic [31:0] p3 [3];
		logic [31:0] v3 [3];
		int r;
		logic [1:0] c;
		logic [15:0] dt;
		for (int n = 0; n < count; n++) begin
			for (int k = 0; k < 3; k++) begin
				p3[k] = rand_word();
				v3[k] = rand_word();
			end
			r = $urandom_range(99);
			// Inserts dominate so that the pool fills and ticks have work to do.
			if (r < 50) c = CMD_INSERT;
			else if (r < 75) c = CMD_REMOVE;
			else if (r < 97) c = CMD_TICK;
			else c = CMD_UNUSED;
			case ($urandom_range(3))
				0: dt = 16'($urandom);
				1: dt = 16'hFFFF;
				2: dt = 0;
				default: dt = 16'($urandom_range(8191));
			endcase
			send_item(c, p3, v3, pick_slot(), dt);
		end
	endtask

	initial begin
		logic [31:0] p3 [3];
		logic [31:0] v3 [3];
		board = new();
		board.clear();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed part: extremes of every field, every command, the unused code.
		for (int k = 0; k < 3; k++) begin
			p3[k] = 32'h7FFF_FFFF;
			v3[k] = 32'h7FFF_FFFF;
		end
		write_reg(REG_ACCEL_X, 32'h7FFF_FFFF);
		write_reg(REG_ACCEL_Y, 32'h8000_0000);
		write_reg(REG_ACCEL_Z, 32'hFFFF_0000);
		write_reg(REG_LIFE_SPAN, 32'h0002_0000);
		send_item(CMD_INSERT, p3, v3, 0, 0);
		for (int k = 0; k < 3; k++) begin
			p3[k] = 32'h8000_0000;
			v3[k] = 32'h8000_0000;
		end
		send_item(CMD_INSERT, p3, v3, 10'h3FF, 16'hFFFF);
		send_item(CMD_TICK, p3, v3, 0, 0);
		send_item(CMD_TICK, p3, v3, 10'h3FF, 16'hFFFF);
		send_item(CMD_UNUSED, p3, v3, 0, 16'h1234);
		send_item(CMD_REMOVE, p3, v3, 10'h3FF, 0);
		send_item(CMD_REMOVE, p3, v3, 0, 0);
		send_item(CMD_REMOVE, p3, v3, 0, 0);
		send_item(CMD_TICK, p3, v3, 0, 16'hFFFF);
		send_item(CMD_TICK, p3, v3, 0, 16'hFFFF);
		send_item(CMD_TICK, p3, v3, 0, 16'hFFFF);
		drain();

		// Fill the pool to the brim, see insert refused, then expire all at once.
		write_reg(REG_LIFE_SPAN, 32'd0);
		send_idle_pct = 30;
		recv_idle_pct = 49;
		for (int n = 0; n < SLOTS + 2; n++)
			send_item(CMD_INSERT, p3, v3, 0, 0);
		send_item(CMD_TICK, p3, v3, 0, 0);
		send_item(CMD_TICK, p3, v3, 0, 1);
		drain();

		// Random phases with changing registers; the sender pauses at each drain.
		write_reg(REG_ACCEL_X, $urandom);
		write_reg(REG_ACCEL_Y, 32'h0000_1000);
		write_reg(REG_ACCEL_Z, 32'hFFFF_F000);
		write_reg(REG_LIFE_SPAN, 32'h0000_8000);
		random_items(200);
		drain();
		send_idle_pct = 49;
		recv_idle_pct = 30;
		write_reg(REG_ACCEL_X, 32'h8000_0000);
		write_reg(REG_ACCEL_Y, $urandom);
		write_reg(REG_ACCEL_Z, 32'h7FFF_FFFF);
		write_reg(REG_LIFE_SPAN, 32'hFFFF_FFFF);
		random_items(200);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_ACCEL_X, 32'd0);
		write_reg(REG_ACCEL_Y, 32'd0);
		write_reg(REG_ACCEL_Z, $urandom);
		write_reg(REG_LIFE_SPAN, 32'h0001_8000);
		random_items(160);
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
